@@ hdl/dpr_pkg.sv @@
// ----------------------------------------------------------------------------
// dpr_pkg: shared definitions for the disparity reprojection block
// Widths, stage counts, register indexes and reset values of the
// stereo disparity to 3-D point pipeline.
// ----------------------------------------------------------------------------
package dpr_pkg;

  // Input field widths.
  localparam int COORD_BITS = 12;
  localparam int DISP_W     = 8;

  // Configuration register width and index width.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Depth quotient: baseline * focal_x / 16 / d stays below 2^(2*CFG_W-4).
  localparam int Z_W = 2 * CFG_W - 4;

  // Pixel offset (16*u - center) as sign and magnitude.
  localparam int SCALED_W = COORD_BITS + 4;
  localparam int DIFF_W   = ((SCALED_W > CFG_W) ? SCALED_W : CFG_W) + 1;
  localparam int MAG_W    = DIFF_W - 1;

  // Lateral product and its quotient by the focal length.
  localparam int PROD_W = Z_W + MAG_W;
  localparam int Q_W    = 32;
  localparam int HI_W   = PROD_W - Q_W;

  // Output field widths.
  localparam int PZ_W = 31;

  // Division bits resolved per pipeline stage.
  localparam int Z_STEP    = 4;
  localparam int Z_STAGES  = Z_W / Z_STEP;
  localparam int XY_STEP   = 4;
  localparam int XY_STAGES = Q_W / XY_STEP;

  // Input stage, depth divider, multiplier stage, lateral dividers.
  localparam int NSTG = Z_STAGES + XY_STAGES + 2;

  // Stream widths.
  localparam int S_TDATA_W = 2 * COORD_BITS + DISP_W;
  localparam int M_TDATA_W = 96;

  // Saturation limits of the lateral coordinates.
  localparam logic [Q_W-1:0] SAT_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] SAT_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Register reset values.
  localparam logic [CFG_W-1:0] BASELINE_RST = 16'd7864;
  localparam logic [CFG_W-1:0] FOCAL_X_RST  = 16'd5396;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 16'd5374;
  localparam logic [CFG_W-1:0] CENTER_X_RST = 16'd5425;
  localparam logic [CFG_W-1:0] CENTER_Y_RST = 16'd3154;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE = 3'd0,
    REG_FOCAL_X  = 3'd1,
    REG_FOCAL_Y  = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4
  } cfg_reg_t;

endpackage

@@ hdl/disparity_to_point_reprojection.sv @@
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection: stereo disparity to 3-D point
// Turns each pixel (column, row, disparity) into a Q15.16 point with the
// pinhole stereo model, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_axis stream, one transaction per pixel, with column
// in tdata[11:0], row in [23:12] and disparity in [31:24]. Each pixel gives
// exactly one point on the m_axis stream: x, y and z in tdata, and tuser
// high when the disparity was nonzero (a zero disparity gives a zero point).
// Camera parameters are written through the cfg channel (index 0 baseline,
// 1 focal_x, 2 focal_y, 3 center_x, 4 center_y); write them only while no
// pixel is in flight. Unknown indexes are ignored; cfg_ready is always high.
// Throughput is one pixel per clock while the skid register is empty. On its
// way to m_axis_tvalid, a pixel is captured by the input stage with the
// baseline times focal product, then it passes seven depth division
// stages of four quotient bits, one multiplier stage, and eight lateral
// division stages of four bits that also resolve saturation, then the
// output register.
// When the receiver stalls, one more point lands in a skid register and
// s_axis_tready then drops until the skid drains; nothing is lost.
// Synchronous reset empties the pipeline and loads the default camera.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection
  import dpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  // Pixel stream. tdata: column, row, disparity.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,

  // Point stream. tdata: point_x, point_y, point_z, one zero pad bit.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // tuser: point_valid.
  output logic                 m_axis_tuser,

  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [CFG_W-1:0] baseline;
  logic [CFG_W-1:0] focal_x;
  logic [CFG_W-1:0] focal_y;
  logic [CFG_W-1:0] center_x;
  logic [CFG_W-1:0] center_y;

  // Pipeline control.
  logic [NSTG-1:0] vld;
  logic            en;

  // Input stage.
  logic [Z_W-1:0]    s0_dnd;
  logic [DISP_W-1:0] s0_d;
  logic [MAG_W-1:0]  s0_magx;
  logic [MAG_W-1:0]  s0_magy;
  logic              s0_sgnx;
  logic              s0_sgny;
  logic              s0_nz;

  // Depth divider stages.
  logic [DISP_W-1:0] z_rem  [Z_STAGES];
  logic [Z_W-1:0]    z_nq   [Z_STAGES];
  logic [DISP_W-1:0] z_d    [Z_STAGES];
  logic [MAG_W-1:0]  z_magx [Z_STAGES];
  logic [MAG_W-1:0]  z_magy [Z_STAGES];
  logic              z_sgnx [Z_STAGES];
  logic              z_sgny [Z_STAGES];
  logic              z_nz   [Z_STAGES];
  logic [DISP_W-1:0] z_rem_next [Z_STAGES];
  logic [Z_W-1:0]    z_nq_next  [Z_STAGES];

  // Multiplier stage.
  logic [PROD_W-1:0] m_prodx;
  logic [PROD_W-1:0] m_prody;
  logic [Z_W-1:0]    m_z;
  logic              m_sgnx;
  logic              m_sgny;
  logic              m_nz;

  // Lateral divider stages.
  logic [CFG_W-1:0] x_rem  [XY_STAGES];
  logic [Q_W-1:0]   x_nq   [XY_STAGES];
  logic             x_ovf  [XY_STAGES];
  logic [CFG_W-1:0] y_rem  [XY_STAGES];
  logic [Q_W-1:0]   y_nq   [XY_STAGES];
  logic             y_ovf  [XY_STAGES];
  logic [Z_W-1:0]   q_z    [XY_STAGES];
  logic             q_sgnx [XY_STAGES];
  logic             q_sgny [XY_STAGES];
  logic             q_nz   [XY_STAGES];
  logic [CFG_W-1:0] x_rem_next [XY_STAGES];
  logic [Q_W-1:0]   x_nq_next  [XY_STAGES];
  logic             x_ovf_next;
  logic [CFG_W-1:0] y_rem_next [XY_STAGES];
  logic [Q_W-1:0]   y_nq_next  [XY_STAGES];
  logic             y_ovf_next;

  // Input stage logic.
  logic [2*CFG_W-1:0] bf_prod;
  logic [DIFF_W-1:0]  diff_x;
  logic [DIFF_W-1:0]  diff_y;

  // Final results and output buffering.
  logic [Q_W-1:0]  fin_x;
  logic [Q_W-1:0]  fin_y;
  logic [PZ_W-1:0] fin_z;
  logic            fin_pv;
  logic [Q_W-1:0]  out_x;
  logic [Q_W-1:0]  out_y;
  logic [PZ_W-1:0] out_z;
  logic            out_pv;
  logic            out_v;
  logic [Q_W-1:0]  sk_x;
  logic [Q_W-1:0]  sk_y;
  logic [PZ_W-1:0] sk_z;
  logic            sk_pv;
  logic            sk_v;
  logic            take;

  // Restoring division of the depth numerator by the disparity.
  function automatic logic [DISP_W+Z_W-1:0] zdiv_steps(
    input logic [DISP_W-1:0] rem,
    input logic [Z_W-1:0]    nq,
    input logic [DISP_W-1:0] dv
  );
    logic [DISP_W-1:0] r;
    logic [Z_W-1:0]    q;
    logic [DISP_W:0]   t;
    r = rem;
    q = nq;
    for (int k = 0; k < Z_STEP; k++) begin
      t = {r, q[Z_W-1]};
      q = {q[Z_W-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t    = t - {1'b0, dv};
        q[0] = 1'b1;
      end
      r = t[DISP_W-1:0];
    end
    return {r, q};
  endfunction

  // Restoring division of a lateral product by a focal length.
  function automatic logic [CFG_W+Q_W-1:0] xydiv_steps(
    input logic [CFG_W-1:0] rem,
    input logic [Q_W-1:0]   nq,
    input logic [CFG_W-1:0] dv
  );
    logic [CFG_W-1:0] r;
    logic [Q_W-1:0]   q;
    logic [CFG_W:0]   t;
    r = rem;
    q = nq;
    for (int k = 0; k < XY_STEP; k++) begin
      t = {r, q[Q_W-1]};
      q = {q[Q_W-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t    = t - {1'b0, dv};
        q[0] = 1'b1;
      end
      r = t[CFG_W-1:0];
    end
    return {r, q};
  endfunction

  // Apply sign and saturation to a lateral quotient magnitude.
  function automatic logic [Q_W-1:0] sat_coord(
    input logic [Q_W-1:0] q,
    input logic           ovf,
    input logic           neg,
    input logic           fzero
  );
    logic [Q_W-1:0] res;
    if (fzero) begin
      res = '0;
    end else if (!neg) begin
      res = (ovf || q[Q_W-1]) ? SAT_MAX : q;
    end else begin
      res = (ovf || (q > SAT_MIN)) ? SAT_MIN : (~q + 1'b1);
    end
    return res;
  endfunction

  // Configuration writes; unknown indexes fall through.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= BASELINE_RST;
      focal_x  <= FOCAL_X_RST;
      focal_y  <= FOCAL_Y_RST;
      center_x <= CENTER_X_RST;
      center_y <= CENTER_Y_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASELINE: baseline <= cfg_data;
        REG_FOCAL_X:  focal_x  <= cfg_data;
        REG_FOCAL_Y:  focal_y  <= cfg_data;
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the skid register is free.
  assign en            = !sk_v;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], s_axis_tvalid};
    end
  end

  // Input stage: baseline times focal_x, pixel offsets as sign and magnitude.
  always_comb begin
    bf_prod = baseline * focal_x;
    diff_x  = DIFF_W'({s_axis_tdata[COORD_BITS-1:0], 4'b0000}) - DIFF_W'(center_x);
    diff_y  = DIFF_W'({s_axis_tdata[2*COORD_BITS-1:COORD_BITS], 4'b0000})
              - DIFF_W'(center_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dnd  <= bf_prod[2*CFG_W-1:4];
      s0_d    <= s_axis_tdata[S_TDATA_W-1:2*COORD_BITS];
      s0_nz   <= |s_axis_tdata[S_TDATA_W-1:2*COORD_BITS];
      s0_sgnx <= diff_x[DIFF_W-1];
      s0_sgny <= diff_y[DIFF_W-1];
      s0_magx <= diff_x[DIFF_W-1] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
      s0_magy <= diff_y[DIFF_W-1] ? MAG_W'(-diff_y) : MAG_W'(diff_y);
    end
  end

  // Depth divider: four quotient bits per stage.
  always_comb begin
    for (int i = 0; i < Z_STAGES; i++) begin
      if (i == 0) begin
        {z_rem_next[i], z_nq_next[i]} = zdiv_steps('0, s0_dnd, s0_d);
      end else begin
        {z_rem_next[i], z_nq_next[i]} = zdiv_steps(z_rem[i-1], z_nq[i-1], z_d[i-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Z_STAGES; i++) begin
        z_rem[i] <= z_rem_next[i];
        z_nq[i]  <= z_nq_next[i];
        if (i == 0) begin
          z_d[i]    <= s0_d;
          z_magx[i] <= s0_magx;
          z_magy[i] <= s0_magy;
          z_sgnx[i] <= s0_sgnx;
          z_sgny[i] <= s0_sgny;
          z_nz[i]   <= s0_nz;
        end else begin
          z_d[i]    <= z_d[i-1];
          z_magx[i] <= z_magx[i-1];
          z_magy[i] <= z_magy[i-1];
          z_sgnx[i] <= z_sgnx[i-1];
          z_sgny[i] <= z_sgny[i-1];
          z_nz[i]   <= z_nz[i-1];
        end
      end
    end
  end

  // Multiplier stage: depth times offset magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      m_prodx <= PROD_W'(z_nq[Z_STAGES-1]) * PROD_W'(z_magx[Z_STAGES-1]);
      m_prody <= PROD_W'(z_nq[Z_STAGES-1]) * PROD_W'(z_magy[Z_STAGES-1]);
      m_z     <= z_nq[Z_STAGES-1];
      m_sgnx  <= z_sgnx[Z_STAGES-1];
      m_sgny  <= z_sgny[Z_STAGES-1];
      m_nz    <= z_nz[Z_STAGES-1];
    end
  end

  // Lateral dividers. The first stage flags a quotient of 2^32 or more and
  // starts from the high product bits as the partial remainder.
  always_comb begin
    x_ovf_next = CFG_W'(m_prodx[PROD_W-1:Q_W]) >= focal_x;
    y_ovf_next = CFG_W'(m_prody[PROD_W-1:Q_W]) >= focal_y;
    for (int i = 0; i < XY_STAGES; i++) begin
      if (i == 0) begin
        {x_rem_next[i], x_nq_next[i]} =
          xydiv_steps(CFG_W'(m_prodx[PROD_W-1:Q_W]), m_prodx[Q_W-1:0], focal_x);
        {y_rem_next[i], y_nq_next[i]} =
          xydiv_steps(CFG_W'(m_prody[PROD_W-1:Q_W]), m_prody[Q_W-1:0], focal_y);
      end else begin
        {x_rem_next[i], x_nq_next[i]} = xydiv_steps(x_rem[i-1], x_nq[i-1], focal_x);
        {y_rem_next[i], y_nq_next[i]} = xydiv_steps(y_rem[i-1], y_nq[i-1], focal_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < XY_STAGES; i++) begin
        x_rem[i] <= x_rem_next[i];
        x_nq[i]  <= x_nq_next[i];
        y_rem[i] <= y_rem_next[i];
        y_nq[i]  <= y_nq_next[i];
        if (i == 0) begin
          x_ovf[i]  <= x_ovf_next;
          y_ovf[i]  <= y_ovf_next;
          q_z[i]    <= m_z;
          q_sgnx[i] <= m_sgnx;
          q_sgny[i] <= m_sgny;
          q_nz[i]   <= m_nz;
        end else begin
          x_ovf[i]  <= x_ovf[i-1];
          y_ovf[i]  <= y_ovf[i-1];
          q_z[i]    <= q_z[i-1];
          q_sgnx[i] <= q_sgnx[i-1];
          q_sgny[i] <= q_sgny[i-1];
          q_nz[i]   <= q_nz[i-1];
        end
      end
    end
  end

  // Final sign, saturation and zeroing of points without a match.
  always_comb begin
    fin_pv = q_nz[XY_STAGES-1];
    fin_x  = '0;
    fin_y  = '0;
    fin_z  = '0;
    if (fin_pv) begin
      fin_x = sat_coord(x_nq[XY_STAGES-1], x_ovf[XY_STAGES-1], q_sgnx[XY_STAGES-1],
                        focal_x == '0);
      fin_y = sat_coord(y_nq[XY_STAGES-1], y_ovf[XY_STAGES-1], q_sgny[XY_STAGES-1],
                        focal_y == '0);
      fin_z = PZ_W'(q_z[XY_STAGES-1]);
    end
  end

  // Output register with one skid entry behind it.
  assign take = out_v && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      sk_v  <= 1'b0;
    end else if (sk_v) begin
      if (take) begin
        sk_v <= 1'b0;
      end
    end else if (vld[NSTG-1]) begin
      if (!out_v || take) begin
        out_v <= 1'b1;
      end else begin
        sk_v <= 1'b1;
      end
    end else if (take) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v) begin
      if (take) begin
        out_x  <= sk_x;
        out_y  <= sk_y;
        out_z  <= sk_z;
        out_pv <= sk_pv;
      end
    end else if (vld[NSTG-1]) begin
      if (!out_v || take) begin
        out_x  <= fin_x;
        out_y  <= fin_y;
        out_z  <= fin_z;
        out_pv <= fin_pv;
      end else begin
        sk_x  <= fin_x;
        sk_y  <= fin_y;
        sk_z  <= fin_z;
        sk_pv <= fin_pv;
      end
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {1'b0, out_z, out_y, out_x};
  assign m_axis_tuser  = out_pv;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_v |-> out_v)
    else $error("skid register holds a point while the output is empty");

  // A finished point meeting a stalled, occupied output goes to the skid.
  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] && !sk_v && out_v && !m_axis_tready |=> sk_v)
    else $error("finished point was not captured by the skid register");

  // A drained skid entry moves to the output and frees the pipeline.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    sk_v && m_axis_tready |=> !sk_v && out_v)
    else $error("skid register did not drain into the output");

  // A point without a match carries all zero coordinates.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_v && !out_pv |-> (out_x == '0) && (out_y == '0) && (out_z == '0))
    else $error("invalid point has nonzero coordinates");
`endif

endmodule

@@ sim/tb_disparity_to_point_reprojection.sv @@
// ----------------------------------------------------------------------------
// tb_disparity_to_point_reprojection: self-checking bench for the reprojection
// Streams pixels through the block under several camera settings, predicts
// each 3-D point in fixed point and compares every output transaction field
// by field, with random gaps on the pixel side and random stalls on the
// point side.
// ----------------------------------------------------------------------------
module tb_disparity_to_point_reprojection;
  import dpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int PHASE_PIXELS   = 148;

  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  // Limits of the lateral coordinates.
  localparam longint LAT_MAX = 64'sd2147483647;
  localparam longint LAT_MIN = -64'sd2147483648;

  // Pixel as it travels in s_axis_tdata, column in the lowest bits.
  typedef struct packed {
    logic [DISP_W-1:0]     disparity;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] column;
  } pixel_t;

  // Point as it travels in m_axis_tdata, x in the lowest bits.
  typedef struct packed {
    logic            pad;
    logic [PZ_W-1:0] z;
    logic [31:0]     y;
    logic [31:0]     x;
  } point_t;

  typedef struct packed {
    logic   valid;
    point_t pt;
  } point_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Camera as the bench believes the block holds it.
  logic [CFG_W-1:0] cam_baseline = BASELINE_RST;
  logic [CFG_W-1:0] cam_focal_x  = FOCAL_X_RST;
  logic [CFG_W-1:0] cam_focal_y  = FOCAL_Y_RST;
  logic [CFG_W-1:0] cam_center_x = CENTER_X_RST;
  logic [CFG_W-1:0] cam_center_y = CENTER_Y_RST;

  pixel_t        pending_pixels[$];
  point_result_t expected_points[$];

  int src_gap;
  bit src_burst;
  int sink_wait;
  bit sink_burst;
  int idle_cycles;
  int mismatches;
  int points_checked;
  int zero_disp_points;
  int saturated_points;
  int camera_settings;

  point_t        got_point;
  point_result_t want_point;

  disparity_to_point_reprojection dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Lateral coordinate: depth times the pixel offset over the focal length,
  // truncated toward zero and clamped to 32 bits.
  function automatic logic [31:0] lateral(longint depth, logic [COORD_BITS-1:0] coord,
                                          logic [CFG_W-1:0] center, logic [CFG_W-1:0] focal);
    longint offset;
    longint q;
    if (focal == '0) return '0;
    offset = 16 * longint'(coord) - longint'(center);
    q = (depth * offset) / longint'(focal);
    if (q > LAT_MAX) q = LAT_MAX;
    if (q < LAT_MIN) q = LAT_MIN;
    return q[31:0];
  endfunction

  // Expected point for one pixel under the current camera.
  function automatic point_result_t reproject(pixel_t p);
    point_result_t r;
    longint depth;
    r = '0;
    if (p.disparity != '0) begin
      depth = (longint'(cam_baseline) * longint'(cam_focal_x)) / (16 * longint'(p.disparity));
      r.valid = 1'b1;
      r.pt.z  = depth[PZ_W-1:0];
      r.pt.x  = lateral(depth, p.column, cam_center_x, cam_focal_x);
      r.pt.y  = lateral(depth, p.row, cam_center_y, cam_focal_y);
    end
    return r;
  endfunction

  // Coordinates lean toward the image borders now and then.
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.column = rand_coord();
    p.row    = rand_coord();
    case ($urandom_range(0, 15))
      0: p.disparity = '0;
      1: p.disparity = '1;
      2: p.disparity = 8'd1;
      default: p.disparity = DISP_W'($urandom_range(1, 255));
    endcase
    return p;
  endfunction

  // Camera values: zero, full scale, small, or anything.
  function automatic logic [CFG_W-1:0] rand_cam();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return CFG_W'($urandom_range(1, 255));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // Append one pixel to the driver's queue.
  task automatic queue_pixel(pixel_t p);
    pending_pixels.insert(pending_pixels.size(), p);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // One register write transaction on the configuration channel.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // Wait until every pixel has gone through and its point has been checked.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_W-1:0] b, logic [CFG_W-1:0] fx, logic [CFG_W-1:0] fy,
                           logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy);
    write_reg(REG_BASELINE, b);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    // A write to an undecoded index must leave the camera alone.
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), CFG_W'($urandom));
    camera_settings++;
    repeat (PHASE_PIXELS) queue_pixel(rand_pixel());
    wait_idle();
  endtask

  // Pixel driver: predicts each accepted pixel and feeds the next one after
  // a random gap.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
      src_burst = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_points.insert(expected_points.size(), reproject(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          s_axis_tdata  <= pending_pixels.pop_front();
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
          src_gap = src_burst ? 0 : $urandom_range(0, 11);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Point monitor: checks each accepted point against the oldest prediction
  // and stalls the stream at random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
      sink_burst = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_point = m_axis_tdata;
        if (expected_points.size() == 0) begin
          mismatches++;
          $display("%0t: point with nothing expected, actual %h", $time, m_axis_tdata);
        end else begin
          want_point = expected_points.pop_front();
          check_field("point_x", want_point.pt.x, got_point.x);
          check_field("point_y", want_point.pt.y, got_point.y);
          check_field("point_z", 32'(want_point.pt.z), 32'(got_point.z));
          check_field("pad bit", 32'(want_point.pt.pad), 32'(got_point.pad));
          check_field("point_valid", 32'(want_point.valid), 32'(m_axis_tuser));
          points_checked++;
          if (!want_point.valid) zero_disp_points++;
          if (want_point.pt.y == LAT_MAX[31:0] || want_point.pt.y == LAT_MIN[31:0])
            saturated_points++;
        end
        if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
        sink_wait = sink_burst ? 0 : $urandom_range(0, 11);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Track register writes the same way the block decodes them.
  always @(posedge clk) begin
    if (rst) begin
      cam_baseline <= BASELINE_RST;
      cam_focal_x  <= FOCAL_X_RST;
      cam_focal_y  <= FOCAL_Y_RST;
      cam_center_x <= CENTER_X_RST;
      cam_center_y <= CENTER_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASELINE: cam_baseline <= cfg_data;
        REG_FOCAL_X:  cam_focal_x  <= cfg_data;
        REG_FOCAL_Y:  cam_focal_y  <= cfg_data;
        REG_CENTER_X: cam_center_x <= cfg_data;
        REG_CENTER_Y: cam_center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Watchdog: too long without any transaction means the block is stuck.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d points outstanding",
               $time, idle_cycles, expected_points.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels under the reset camera: image corners, zero, unit and
    // full disparity, and the pixel nearest the principal point.
    queue_pixel('{disparity: 8'd0,   row: 12'd0,    column: 12'd0});
    queue_pixel('{disparity: 8'd0,   row: 12'd4095, column: 12'd4095});
    queue_pixel('{disparity: 8'd1,   row: 12'd0,    column: 12'd0});
    queue_pixel('{disparity: 8'd1,   row: 12'd4095, column: 12'd4095});
    queue_pixel('{disparity: 8'd255, row: 12'd4095, column: 12'd0});
    queue_pixel('{disparity: 8'd255, row: 12'd0,    column: 12'd4095});
    queue_pixel('{disparity: 8'd1,   row: 12'd197,  column: 12'd339});
    queue_pixel('{disparity: 8'd7,   row: 12'd197,  column: 12'd339});
    queue_pixel('{disparity: 8'd128, row: 12'd2048, column: 12'd2048});
    queue_pixel('{disparity: 8'd2,   row: 12'd1,    column: 12'd1});
    queue_pixel('{disparity: 8'd3,   row: 12'd2730, column: 12'd1365});
    queue_pixel('{disparity: 8'd170, row: 12'd1365, column: 12'd2730});
    queue_pixel('{disparity: 8'd85,  row: 12'd4095, column: 12'd0});
    queue_pixel('{disparity: 8'd0,   row: 12'd1000, column: 12'd2000});
    queue_pixel('{disparity: 8'd64,  row: 12'd480,  column: 12'd640});
    queue_pixel('{disparity: 8'd254, row: 12'd1,    column: 12'd4094});
    camera_settings = 1;
    wait_idle();

    // Full-scale camera with the principal point at both ends.
    run_phase('1, '1, '1, '0, '1);
    // Tiny vertical focal length: the row offset saturates both ways.
    run_phase('1, '1, 16'd1, '1, 16'd32768);
    // Zero baseline and zero vertical focal length.
    run_phase('0, 16'd1, '0, '0, '0);
    // Zero horizontal focal length.
    run_phase(16'd1, '0, '1, 16'd40000, 16'd1);
    for (int i = 0; i < 8; i++)
      run_phase(rand_cam(), rand_cam(), rand_cam(), rand_cam(), rand_cam());
    // Back to the default camera.
    run_phase(BASELINE_RST, FOCAL_X_RST, FOCAL_Y_RST, CENTER_X_RST, CENTER_Y_RST);

    $display("Checked %0d points over %0d camera settings, %0d of them with zero disparity",
             points_checked, camera_settings, zero_disp_points);
    $display("and %0d with a saturated row offset; %0d mismatches.",
             saturated_points, mismatches);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/dpr_pkg.sv
hdl/disparity_to_point_reprojection.sv
sim/tb_disparity_to_point_reprojection.sv
